[hdl/sfc_pkg.sv]
`timescale 1ns / 1ps

package sfc_pkg;

  localparam int unsigned MaskW   = 64;
  localparam int unsigned PageW   = 4;
  localparam int unsigned LabelW  = 8;
  localparam int unsigned TimerW  = 32;
  localparam int unsigned SecW    = 23;
  localparam int unsigned PassW   = 8;

  // seconds = floor((ms >> 3) * RecipMul >> RecipShift), exact for 32-bit ms
  localparam int unsigned RecipShift = 36;
  localparam logic [29:0] RecipMul   = 30'd549755814;

  localparam logic [1:0] KindLoadTrans = 2'd0;
  localparam logic [1:0] KindLoadStep  = 2'd1;
  localparam logic [1:0] KindScan      = 2'd2;

  typedef struct packed {
    logic [PageW-1:0] page;
    logic [MaskW-1:0] up;
    logic [MaskW-1:0] dn;
  } trans_entry_t;

  typedef struct packed {
    logic              en;
    trans_entry_t      ent;
  } trans_rd_t;

  typedef struct packed {
    logic [LabelW-1:0] label;
    logic [TimerW-1:0] timer;
  } step_entry_t;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_PASS = 6'b000010,
    S_RD   = 6'b000100,
    S_UPD  = 6'b001000,
    S_MUL  = 6'b010000,
    S_SEND = 6'b100000
  } state_e;

endpackage

[hdl/sfc_transition_evaluator_top.sv]
`timescale 1ns / 1ps

// Sequential function chart evaluator. Load words (tuser 0: transition, 1: step slot) are taken
// while idle and give no output. A scan word (tuser 2) runs passes over the transition memory,
// one transition per cycle, up to MAX_PASSES passes while a pass fires a transition, then walks
// the step memory slot by slot through read, timer update, seconds multiply and send states,
// giving one output word per step slot; the send state waits while the output side stalls.
// tuser 3 is dropped.
module sfc_transition_evaluator_top #(
  parameter int unsigned NUM_STEPS       = 64,
  parameter int unsigned NUM_TRANSITIONS = 64,
  parameter int unsigned MAX_PASSES      = 50,
  parameter int unsigned NUM_PAGES       = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [9:0]   cfg_wdata_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // slot_index[5:0], page[9:6], upstream_mask[73:10], downstream_mask[137:74],
  // step_label[145:138], initial_active[146], conditions[210:147], zero pad
  input  logic [215:0] s_axis_tdata,
  // kind
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // step_label_out[7:0], active[8], seconds_active[31:9], pass_limit_hit[32], zero pad
  output logic [39:0]  m_axis_tdata,
  output logic         m_axis_tlast
);

  localparam int unsigned TIdxW = $clog2(NUM_TRANSITIONS);
  localparam int unsigned TCntW = $clog2(NUM_TRANSITIONS + 1);
  localparam int unsigned SIdxW = $clog2(NUM_STEPS);
  localparam int unsigned SCntW = $clog2(NUM_STEPS + 1);

  logic [5:0]   in_slot;
  logic [3:0]   in_page;
  logic [63:0]  in_up, in_dn, in_cond;
  logic [7:0]   in_label;
  logic         in_init;
  logic         in_acc;

  assign in_slot  = s_axis_tdata[5:0];
  assign in_page  = s_axis_tdata[9:6];
  assign in_up    = s_axis_tdata[73:10];
  assign in_dn    = s_axis_tdata[137:74];
  assign in_label = s_axis_tdata[145:138];
  assign in_init  = s_axis_tdata[146];
  assign in_cond  = s_axis_tdata[210:147];

  sfc_pkg::state_e state_q, state_d;

  logic [9:0]                 period_q;
  logic [NUM_STEPS-1:0]       act_q, act_d;
  logic [3:0]                 page_q;
  logic [NUM_TRANSITIONS-1:0] cond_q;
  logic [TCntW-1:0]           t_q, t_d;
  logic                       ev_q, ev_d;
  logic [TIdxW-1:0]           ev_idx_q;
  logic                       fired_q, fired_d;
  logic [sfc_pkg::PassW-1:0]  passes_q, passes_d;
  logic                       limit_q, limit_d;
  logic [SCntW-1:0]           s_q, s_d;
  logic [31:0]                tnew_q;
  logic [7:0]                 label_q;
  logic [58:0]                prod_q;

  logic        out_vld_q;
  logic [7:0]  out_label_q;
  logic        out_act_q;
  logic [22:0] out_sec_q;
  logic        out_limit_q;
  logic        out_last_q;

  // memories
  logic                   tm_we;
  sfc_pkg::trans_entry_t  tm_wdata;
  sfc_pkg::trans_rd_t     tm_rdata;
  logic                   sm_we;
  logic [SIdxW-1:0]       sm_waddr;
  sfc_pkg::step_entry_t   sm_wdata;
  sfc_pkg::step_entry_t   sm_rdata;

  assign s_axis_tready = (state_q == sfc_pkg::S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  assign tm_we          = in_acc && (s_axis_tuser == sfc_pkg::KindLoadTrans) &&
                          (32'(in_slot) < NUM_TRANSITIONS);
  assign tm_wdata.page  = in_page;
  assign tm_wdata.up    = in_up;
  assign tm_wdata.dn    = in_dn;

  sfc_trans_mem #(
    .Depth (NUM_TRANSITIONS),
    .IdxW  (TIdxW)
  ) u_trans_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (tm_we),
    .waddr_i (in_slot[TIdxW-1:0]),
    .wdata_i (tm_wdata),
    .raddr_i (t_q[TIdxW-1:0]),
    .rdata_o (tm_rdata)
  );

  logic step_load;
  assign step_load = in_acc && (s_axis_tuser == sfc_pkg::KindLoadStep) &&
                     (32'(in_slot) < NUM_STEPS);

  function automatic logic [31:0] tnew_calc();
    logic [32:0] sum;
    sum = {1'b0, sm_rdata.timer} + {23'd0, period_q};
    if (!act_q[s_q[SIdxW-1:0]]) begin
      return '0;
    end
    return sum[32] ? 32'hFFFF_FFFF : sum[31:0];
  endfunction

  // timer write-back during a scan, slot load otherwise
  always_comb begin
    sm_we    = step_load || (state_q == sfc_pkg::S_UPD);
    sm_waddr = (state_q == sfc_pkg::S_UPD) ? s_q[SIdxW-1:0] : in_slot[SIdxW-1:0];
    if (state_q == sfc_pkg::S_UPD) begin
      sm_wdata.label = sm_rdata.label;
      sm_wdata.timer = tnew_calc();
    end else begin
      sm_wdata.label = in_label;
      sm_wdata.timer = '0;
    end
  end

  sfc_step_mem #(
    .Depth (NUM_STEPS),
    .IdxW  (SIdxW)
  ) u_step_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (sm_we),
    .waddr_i (sm_waddr),
    .wdata_i (sm_wdata),
    .raddr_i (s_q[SIdxW-1:0]),
    .rdata_o (sm_rdata)
  );

  logic                 fire;
  logic [NUM_STEPS-1:0] up_m, dn_m;
  logic                 t_issue;
  logic                 pass_more;
  logic                 out_free;

  assign up_m    = tm_rdata.ent.up[NUM_STEPS-1:0];
  assign dn_m    = tm_rdata.ent.dn[NUM_STEPS-1:0];
  assign fire    = ev_q && tm_rdata.en && (tm_rdata.ent.page == page_q) &&
                   cond_q[ev_idx_q] && ((act_q & up_m) == up_m);
  assign t_issue = (32'(t_q) < NUM_TRANSITIONS);
  assign pass_more = fired_q &&
                     ({1'b0, passes_q} + 9'd1 < 9'(MAX_PASSES));
  assign out_free  = !out_vld_q || m_axis_tready;

  always_comb begin
    state_d  = state_q;
    act_d    = act_q;
    t_d      = t_q;
    ev_d     = 1'b0;
    fired_d  = fired_q;
    passes_d = passes_q;
    limit_d  = limit_q;
    s_d      = s_q;
    case (state_q)
      sfc_pkg::S_IDLE: begin
        if (step_load) begin
          act_d[in_slot[SIdxW-1:0]] = in_init;
        end
        if (in_acc && (s_axis_tuser == sfc_pkg::KindScan)) begin
          t_d      = '0;
          fired_d  = 1'b0;
          passes_d = '0;
          limit_d  = 1'b0;
          s_d      = '0;
          state_d  = (32'(in_page) < NUM_PAGES) ? sfc_pkg::S_PASS : sfc_pkg::S_RD;
        end
      end
      sfc_pkg::S_PASS: begin
        if (fire) begin
          act_d   = (act_q & ~up_m) | dn_m;
          fired_d = 1'b1;
        end
        if (t_issue) begin
          ev_d = 1'b1;
          t_d  = t_q + TCntW'(1);
        end else if (!ev_q) begin
          passes_d = passes_q + 8'd1;
          if (pass_more) begin
            t_d     = '0;
            fired_d = 1'b0;
          end else begin
            limit_d = fired_q;
            state_d = sfc_pkg::S_RD;
          end
        end
      end
      sfc_pkg::S_RD:  state_d = sfc_pkg::S_UPD;
      sfc_pkg::S_UPD: state_d = sfc_pkg::S_MUL;
      sfc_pkg::S_MUL: state_d = sfc_pkg::S_SEND;
      sfc_pkg::S_SEND: begin
        if (out_free) begin
          s_d = s_q + SCntW'(1);
          state_d = (32'(s_q) == NUM_STEPS - 1) ? sfc_pkg::S_IDLE : sfc_pkg::S_RD;
        end
      end
      default: state_d = sfc_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= sfc_pkg::S_IDLE;
      period_q  <= 10'd100;
      act_q     <= '0;
      t_q       <= '0;
      ev_q      <= 1'b0;
      fired_q   <= 1'b0;
      passes_q  <= '0;
      limit_q   <= 1'b0;
      s_q       <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      if (cfg_we_i) begin
        period_q <= cfg_wdata_i;
      end
      act_q    <= act_d;
      t_q      <= t_d;
      ev_q     <= ev_d;
      fired_q  <= fired_d;
      passes_q <= passes_d;
      limit_q  <= limit_d;
      s_q      <= s_d;
      if (state_q == sfc_pkg::S_SEND && out_free) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      page_q <= in_page;
      cond_q <= in_cond[NUM_TRANSITIONS-1:0];
    end
    ev_idx_q <= t_q[TIdxW-1:0];
    if (state_q == sfc_pkg::S_UPD) begin
      tnew_q  <= tnew_calc();
      label_q <= sm_rdata.label;
    end
    prod_q <= tnew_q[31:3] * sfc_pkg::RecipMul;
    if (state_q == sfc_pkg::S_SEND && out_free) begin
      out_label_q <= label_q;
      out_act_q   <= act_q[s_q[SIdxW-1:0]];
      out_sec_q   <= prod_q[58:36];
      out_limit_q <= limit_q;
      out_last_q  <= (32'(s_q) == NUM_STEPS - 1);
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {7'd0, out_limit_q, out_sec_q, out_act_q, out_label_q};
  assign m_axis_tlast  = out_last_q;

endmodule

[hdl/sfc_trans_mem.sv]
`timescale 1ns / 1ps

module sfc_trans_mem #(
  parameter int unsigned Depth = 64,
  parameter int unsigned IdxW  = 6
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 we_i,
  input  logic [IdxW-1:0]      waddr_i,
  input  sfc_pkg::trans_entry_t wdata_i,
  input  logic [IdxW-1:0]      raddr_i,
  output sfc_pkg::trans_rd_t   rdata_o
);

  sfc_pkg::trans_entry_t mem [Depth];
  logic [Depth-1:0]      en_q;
  sfc_pkg::trans_entry_t rd_q;
  logic                  rd_en_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rd_q <= mem[raddr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q    <= '0;
      rd_en_q <= 1'b0;
    end else begin
      if (we_i) begin
        en_q[waddr_i] <= 1'b1;
      end
      rd_en_q <= en_q[raddr_i];
    end
  end

  assign rdata_o.en  = rd_en_q;
  assign rdata_o.ent = rd_q;

endmodule

[hdl/sfc_step_mem.sv]
`timescale 1ns / 1ps

module sfc_step_mem #(
  parameter int unsigned Depth = 64,
  parameter int unsigned IdxW  = 6
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                we_i,
  input  logic [IdxW-1:0]     waddr_i,
  input  sfc_pkg::step_entry_t wdata_i,
  input  logic [IdxW-1:0]     raddr_i,
  output sfc_pkg::step_entry_t rdata_o
);

  sfc_pkg::step_entry_t mem [Depth];
  logic [Depth-1:0]     vld_q;
  sfc_pkg::step_entry_t rd_q;
  logic                 rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rd_q <= mem[raddr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (we_i) begin
        vld_q[waddr_i] <= 1'b1;
      end
      rd_vld_q <= vld_q[raddr_i];
    end
  end

  // never-written entries read as zero
  assign rdata_o = rd_vld_q ? rd_q : '0;

endmodule

[tb/sfc_scan_checker.sv]
`timescale 1ns / 1ps

module sfc_scan_checker (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [9:0]   cfg_wdata_i,
  input  logic         s_tvalid_i,
  input  logic         s_tready_i,
  input  logic [215:0] s_tdata_i,
  input  logic [1:0]   s_tuser_i,
  input  logic         m_tvalid_i,
  input  logic         m_tready_i,
  input  logic [39:0]  m_tdata_i,
  input  logic         m_tlast_i,
  output int           fail_count_o,
  output int           pending_o
);

  localparam int NSteps = 64;
  localparam int NTrans = 64;
  localparam int PassLimit = 50;

  typedef struct packed {
    logic [7:0]  label;
    logic        active;
    logic [22:0] secs;
    logic        limit_hit;
    logic        last;
  } step_report_t;

  logic [9:0]        period_ms;
  logic [NTrans-1:0] trans_en;
  logic [3:0]        trans_pg  [NTrans];
  logic [63:0]       trans_up  [NTrans];
  logic [63:0]       trans_dn  [NTrans];
  logic [63:0]       act_steps;
  logic [31:0]       timer_ms  [NSteps];
  logic [7:0]        labels    [NSteps];
  step_report_t      report_q[$];

  assign pending_o = report_q.size();

  // evaluate one scan of a page and queue the per-step reports
  function automatic void evaluate_scan(input logic [3:0] pg, input logic [63:0] cond);
    int          passes;
    logic        fired;
    logic [32:0] sum;
    step_report_t r;
    passes = 0;
    fired = 1'b0;
    do begin
      fired = 1'b0;
      for (int t = 0; t < NTrans; t++) begin
        if (trans_en[t] && trans_pg[t] == pg && cond[t] &&
            (act_steps & trans_up[t]) == trans_up[t]) begin
          act_steps = (act_steps & ~trans_up[t]) | trans_dn[t];
          fired = 1'b1;
        end
      end
      passes++;
    end while (fired && passes < PassLimit);
    for (int s = 0; s < NSteps; s++) begin
      if (act_steps[s]) begin
        sum = {1'b0, timer_ms[s]} + {23'd0, period_ms};
        timer_ms[s] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
      end else begin
        timer_ms[s] = '0;
      end
      r.label = labels[s];
      r.active = act_steps[s];
      r.secs = 23'(timer_ms[s] / 1000);
      r.limit_hit = fired && passes >= PassLimit;
      r.last = (s == NSteps - 1);
      report_q.push_back(r);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    step_report_t exp_r;
    step_report_t got;
    int slot;
    if (!rst_ni) begin
      period_ms <= 10'd100;
      trans_en <= '0;
      act_steps <= '0;
      for (int i = 0; i < NSteps; i++) begin
        timer_ms[i] <= '0;
        labels[i] <= '0;
        trans_pg[i] <= '0;
        trans_up[i] <= '0;
        trans_dn[i] <= '0;
      end
      report_q.delete();
      fail_count_o <= 0;
    end else begin
      if (cfg_we_i) period_ms = cfg_wdata_i;
      if (s_tvalid_i && s_tready_i) begin
        slot = int'(s_tdata_i[5:0]);
        case (s_tuser_i)
          sfc_pkg::KindLoadTrans: begin
            trans_en[slot] = 1'b1;
            trans_pg[slot] = s_tdata_i[9:6];
            trans_up[slot] = s_tdata_i[73:10];
            trans_dn[slot] = s_tdata_i[137:74];
          end
          sfc_pkg::KindLoadStep: begin
            labels[slot] = s_tdata_i[145:138];
            timer_ms[slot] = '0;
            act_steps[slot] = s_tdata_i[146];
          end
          sfc_pkg::KindScan: evaluate_scan(s_tdata_i[9:6], s_tdata_i[210:147]);
          default: ;
        endcase
      end
      if (m_tvalid_i && m_tready_i) begin
        got = {m_tdata_i[7:0], m_tdata_i[8], m_tdata_i[31:9], m_tdata_i[32], m_tlast_i};
        if (report_q.size() == 0) begin
          $display("%0t: unexpected word, expected none, got %h", $time, got);
          fail_count_o <= fail_count_o + 1;
        end else begin
          exp_r = report_q.pop_front();
          if (got !== exp_r) begin
            $display("%0t: step word, expected label %h act %b sec %0d lim %b last %b,",
                     $time, exp_r.label, exp_r.active, exp_r.secs, exp_r.limit_hit,
                     exp_r.last);
            $display("%0t:   got label %h act %b sec %0d lim %b last %b", $time,
                     got.label, got.active, got.secs, got.limit_hit, got.last);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
    end
  end

endmodule

[tb/sfc_transition_evaluator_top_test.sv]
`timescale 1ns / 1ps

module sfc_transition_evaluator_top_test;

  localparam int WatchLimit = 20000;
  localparam logic [1:0] KindUnused = 2'd3;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         cfg_we = 1'b0;
  logic [9:0]   cfg_wdata = '0;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [215:0] s_tdata = '0;
  logic [1:0]   s_tuser = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [39:0]  m_tdata;
  logic         m_tlast;
  int           fail_count;
  int           pending;
  logic         no_idle = 1'b0;
  int           out_wait = 0;
  int           quiet_cycles = 0;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  sfc_transition_evaluator_top u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .s_axis_tvalid(s_tvalid),
    .s_axis_tready(s_tready),
    .s_axis_tdata (s_tdata),
    .s_axis_tuser (s_tuser),
    .m_axis_tvalid(m_tvalid),
    .m_axis_tready(m_tready),
    .m_axis_tdata (m_tdata),
    .m_axis_tlast (m_tlast)
  );

  sfc_scan_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .s_tvalid_i  (s_tvalid),
    .s_tready_i  (s_tready),
    .s_tdata_i   (s_tdata),
    .s_tuser_i   (s_tuser),
    .m_tvalid_i  (m_tvalid),
    .m_tready_i  (m_tready),
    .m_tdata_i   (m_tdata),
    .m_tlast_i   (m_tlast),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  // output side: a fresh random stall after every accepted word, none while no_idle is set
  always @(posedge clk_i) begin
    int w;
    w = out_wait;
    if (m_tvalid && m_tready) w = no_idle ? 0 : int'($urandom_range(0, 7));
    else if (w > 0) w--;
    out_wait <= w;
    m_tready <= rst_ni && (w == 0);
  end

  always @(posedge clk_i) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchLimit) begin
      $display("sfc_transition_evaluator_top: mismatch");
      $finish;
    end
  end

  function automatic logic [215:0] pack_word(input logic [5:0] slot, input logic [3:0] pg,
                                             input logic [63:0] up, input logic [63:0] dn,
                                             input logic [7:0] label, input logic init,
                                             input logic [63:0] cond);
    return {5'b0, cond, init, label, dn, up, pg, slot};
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic send_word(input logic [1:0] kind, input logic [215:0] data);
    int gap;
    gap = no_idle ? 0 : int'($urandom_range(0, 7));
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tuser <= kind;
    s_tdata <= data;
    do @(posedge clk_i); while (!s_tready);
  endtask

  task automatic write_period(input logic [9:0] val);
    s_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_wdata <= val;
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  // a small chart mostly on one page over steps 0..7, interleaved with random scans
  task automatic chart_phase(input int n_items);
    logic [3:0] pg;
    int r;
    pg = 4'($urandom_range(0, 15));
    for (int i = 0; i < n_items; i++) begin
      r = int'($urandom_range(0, 19));
      if (r < 4) begin
        send_word(sfc_pkg::KindLoadStep, pack_word(6'($urandom_range(0, 7)), 4'($urandom),
                                                   rand64(), rand64(), 8'($urandom),
                                                   1'($urandom), rand64()));
      end else if (r < 9) begin
        send_word(sfc_pkg::KindLoadTrans, pack_word(6'($urandom_range(0, 15)), pg,
                                                    64'($urandom_range(1, 255)),
                                                    64'($urandom_range(0, 255)),
                                                    8'($urandom), 1'($urandom), rand64()));
      end else if (r < 17) begin
        send_word(sfc_pkg::KindScan, pack_word(6'($urandom), pg, rand64(), rand64(),
                                               8'($urandom), 1'($urandom), rand64()));
      end else if (r == 17) begin
        send_word(sfc_pkg::KindLoadTrans, pack_word(6'($urandom), 4'($urandom), rand64(),
                                                    rand64(), 8'($urandom), 1'($urandom),
                                                    rand64()));
      end else if (r == 18) begin
        send_word(sfc_pkg::KindScan, pack_word(6'($urandom), 4'($urandom), rand64(),
                                               rand64(), 8'($urandom), 1'($urandom),
                                               rand64()));
      end else begin
        send_word(KindUnused, {24'($urandom), rand64(), rand64(), rand64()});
      end
    end
  endtask

  initial begin
    logic [9:0] periods [6];
    periods = '{10'd1000, 10'd1, 10'd0, 10'd1023, 10'd100, 10'd537};
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes, every kind, cycling chart, empty upstream set
    no_idle <= 1'b1;
    send_word(sfc_pkg::KindLoadStep, pack_word(6'd0, 4'd0, '0, '0, 8'hFF, 1'b1, '0));
    send_word(sfc_pkg::KindLoadStep, pack_word(6'd63, 4'hF, '1, '1, 8'hAA, 1'b0, '1));
    send_word(sfc_pkg::KindLoadTrans, pack_word(6'd0, 4'd0, 64'h1, 64'h2, '0, 1'b0, '0));
    send_word(sfc_pkg::KindLoadTrans, pack_word(6'd1, 4'd0, 64'h2, 64'h8000_0000_0000_0001,
                                                '1, 1'b1, '1));
    send_word(sfc_pkg::KindScan, pack_word('0, 4'd0, '0, '0, '0, 1'b0, '1));
    send_word(sfc_pkg::KindScan, pack_word('1, 4'd0, '1, '1, '1, 1'b1, '0));
    no_idle <= 1'b0;
    send_word(sfc_pkg::KindLoadTrans, pack_word(6'd63, 4'hF, '0, 64'h20, '0, 1'b0, '0));
    send_word(sfc_pkg::KindScan, pack_word('0, 4'hF, '0, '0, '0, 1'b0,
                                           64'h8000_0000_0000_0000));
    send_word(KindUnused, '1);
    send_word(sfc_pkg::KindScan, pack_word('0, 4'd3, '0, '0, '0, 1'b0, '1));
    send_word(sfc_pkg::KindLoadTrans, pack_word(6'd62, 4'hF, '1, '1, '0, 1'b0, '0));
    send_word(sfc_pkg::KindLoadStep, pack_word(6'd5, 4'd0, '0, '0, 8'h00, 1'b0, '0));
    send_word(sfc_pkg::KindScan, pack_word('0, 4'hF, '0, '0, '0, 1'b0, '1));

    for (int ph = 0; ph < 6; ph++) begin
      write_period(periods[ph]);
      no_idle <= (ph == 3);
      chart_phase(22);
    end
    s_tvalid <= 1'b0;

    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("sfc_transition_evaluator_top: match");
    end else begin
      $display("sfc_transition_evaluator_top: mismatch");
    end
    $finish;
  end

endmodule
